>>> rtl/gscm_pkg.sv
// Shared types and constants for the gradient stop colormap unit.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package gscm_pkg;

   localparam int MAX_STOPS_DEF = 6;
   localparam int LEVEL_COUNT   = 256;
   localparam int STOP_REGS     = 6;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int STOP_CNT_W    = 3;
   localparam int QUEUE_DEPTH   = 4;
   localparam int CHANNELS      = 3;
   localparam int QUOT_W        = 8;
   localparam int NUM_W         = 17;
   localparam int DEN_W         = 9;

   // Highest level that reaches the search; larger codes saturate here.
   localparam logic [7:0] LEVEL_MAX =
      (LEVEL_COUNT > 256) ? 8'hFF : 8'(LEVEL_COUNT - 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_0     = 3'd1;

   localparam logic [STOP_CNT_W-1:0] STOP_COUNT_RST = 3'd2;
   localparam logic [CSR_DATA_W-1:0] STOP_1_RST     = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0] pos;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } stop_type;

   // Segment chosen by the search, span forced to 1 with zero distance
   // when the stops do not rise.
   typedef struct packed {
      logic [7:0] span;
      logic [7:0] delta;
      stop_type   a;
      stop_type   b;
   } seg_type;

   // Queue entry: rounding numerators and the doubled span.
   typedef struct packed {
      logic [NUM_W-1:0] num_r;
      logic [NUM_W-1:0] num_g;
      logic [NUM_W-1:0] num_b;
      logic [DEN_W-1:0] den;
   } item_type;

endpackage

>>> rtl/gradient_stop_colormap_unit.sv
// Gradient stop colormap: level in, interpolated RGB out.
// Throughput: one item per cycle; the front pipe, the queue and the
// 8-stage divider pipe each move every cycle while rsp_tready is high.
// Reset: synchronous, active high; clears the pipes and the queue and
// loads stop_count = 2, stop_1 = all ones, other stops zero.
`timescale 1ns / 1ps

module gradient_stop_colormap_unit import gscm_pkg::*; #(
   parameter int MAX_STOPS = MAX_STOPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // Input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] level
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

   // Front end to queue
   logic       front_valid;
   logic       front_ready;
   item_type   front_item;

   // Queue to divider pipe
   logic       queue_valid;
   logic       queue_ready;
   item_type   queue_item;

   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   // Front end: hold the stop registers, saturate the level, find the
   // segment and build the rounding numerators over two stages. It stalls
   // only when the queue is full.
   gscm_front #(
      .MAX_STOPS (MAX_STOPS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_level  (req_tdata),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   // Decouple the two halves so a stalled result side does not stop
   // the front end at once.
   gscm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   // Back end: divide each numerator by twice the span, one quotient bit
   // per stage; the last stage is the output register.
   gscm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (queue_valid),
      .in_ready  (queue_ready),
      .in_item   (queue_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_red   (red),
      .out_green (green),
      .out_blue  (blue)
   );

   assign rsp_tdata = {blue, green, red};

endmodule

>>> rtl/gscm_front.sv
// Front end: configuration registers, stop search and numerator build.
// Depends on gscm_pkg.
`timescale 1ns / 1ps

module gscm_front import gscm_pkg::*; #(
   parameter int MAX_STOPS = MAX_STOPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            in_level,
   output logic                  out_valid,
   input  logic                  out_ready,
   output item_type              out_item
);

   localparam int CNT_W = $clog2(MAX_STOPS + 1);
   localparam int IDX_W = $clog2(MAX_STOPS);
   localparam logic [3:0] MAX_CNT = 4'(MAX_STOPS);

   logic [STOP_CNT_W-1:0]       stop_count_ff, stop_count_in;
   stop_type [MAX_STOPS-1:0]    stops_ff, stops_in;
   logic                        a_valid_ff, a_valid_in;
   seg_type                     a_seg_ff, a_seg_in;
   logic                        b_valid_ff, b_valid_in;
   item_type                    b_item_ff, b_item_in;

   logic                        advance;
   logic [7:0]                  lvl;
   logic [3:0]                  cnt_ext;
   logic [CNT_W-1:0]            n_use;
   logic [IDX_W-1:0]            k_idx, kb_idx;
   logic [CNT_W-1:0]            k_next;
   logic                        stop_found;
   stop_type                    sa, sb;

   function automatic logic [NUM_W-1:0] mix_num(input logic [7:0] ca, input logic [7:0] cb,
                                                input logic [7:0] d, input logic [7:0] span);
      logic [15:0] prod_a;
      logic [15:0] prod_b;
      logic [15:0] num;
      prod_a = {8'd0, ca} * {8'd0, 8'(span - d)};
      prod_b = {8'd0, cb} * {8'd0, d};
      num    = prod_a + prod_b;
      return {num, 1'b0} + {9'd0, span};
   endfunction

   // Register writes
   always_comb begin
      stop_count_in = stop_count_ff;
      stops_in      = stops_ff;
      if (csr_we) begin
         if (csr_index == REG_STOP_COUNT) begin
            stop_count_in = csr_wdata[STOP_CNT_W-1:0];
         end
         for (int i = 0; i < MAX_STOPS; i++) begin
            if ((i < STOP_REGS) && (csr_index == REG_STOP_0 + CSR_IDX_W'(i))) begin
               stops_in[i] = stop_type'(csr_wdata);
            end
         end
      end
   end

   // Segment search: first stop whose successor does not lie strictly below the level
   always_comb begin
      lvl     = (in_level > LEVEL_MAX) ? LEVEL_MAX : in_level;
      cnt_ext = {1'b0, stop_count_ff};
      if (cnt_ext == 4'd0) begin
         n_use = CNT_W'(1);
      end else if (cnt_ext > MAX_CNT) begin
         n_use = CNT_W'(MAX_STOPS);
      end else begin
         n_use = CNT_W'(cnt_ext);
      end

      k_idx      = '0;
      stop_found = 1'b0;
      for (int i = 1; i < MAX_STOPS; i++) begin
         if (!stop_found) begin
            if ((CNT_W'(i) < n_use) && (stops_ff[i].pos < lvl)) begin
               k_idx = IDX_W'(i);
            end else begin
               stop_found = 1'b1;
            end
         end
      end

      k_next = CNT_W'(k_idx) + CNT_W'(1);
      kb_idx = (k_next < n_use) ? IDX_W'(k_next) : IDX_W'(n_use - CNT_W'(1));

      sa = '0;
      sb = '0;
      for (int i = 0; i < MAX_STOPS; i++) begin
         if (k_idx == IDX_W'(i)) begin
            sa = stops_ff[i];
         end
         if (kb_idx == IDX_W'(i)) begin
            sb = stops_ff[i];
         end
      end

      a_seg_in   = '0;
      a_seg_in.a = sa;
      a_seg_in.b = sb;
      if (sb.pos > sa.pos) begin
         a_seg_in.span = sb.pos - sa.pos;
         if (lvl <= sa.pos) begin
            a_seg_in.delta = 8'd0;
         end else if (lvl - sa.pos > a_seg_in.span) begin
            a_seg_in.delta = a_seg_in.span;
         end else begin
            a_seg_in.delta = lvl - sa.pos;
         end
      end else begin
         a_seg_in.span  = 8'd1;
         a_seg_in.delta = 8'd0;
      end
   end

   // Two-stage pipe, held as one while the queue is full
   always_comb begin
      advance         = !b_valid_ff || out_ready;
      a_valid_in      = in_valid;
      b_valid_in      = a_valid_ff;
      b_item_in.num_r = mix_num(a_seg_ff.a.red, a_seg_ff.b.red, a_seg_ff.delta, a_seg_ff.span);
      b_item_in.num_g = mix_num(a_seg_ff.a.green, a_seg_ff.b.green, a_seg_ff.delta,
                                a_seg_ff.span);
      b_item_in.num_b = mix_num(a_seg_ff.a.blue, a_seg_ff.b.blue, a_seg_ff.delta,
                                a_seg_ff.span);
      b_item_in.den   = {a_seg_ff.span, 1'b0};
   end

   assign in_ready  = advance;
   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= STOP_COUNT_RST;
         for (int i = 0; i < MAX_STOPS; i++) begin
            if (i == 1) begin
               stops_ff[i] <= stop_type'(STOP_1_RST);
            end else begin
               stops_ff[i] <= '0;
            end
         end
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
      end else begin
         stop_count_ff <= stop_count_in;
         stops_ff      <= stops_in;
         if (advance) begin
            a_valid_ff <= a_valid_in;
            b_valid_ff <= b_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_seg_ff  <= a_seg_in;
         b_item_ff <= b_item_in;
      end
   end

endmodule

>>> rtl/gscm_queue.sv
// Short queue between the front end and the divider pipe.
// Depends on gscm_pkg.
`timescale 1ns / 1ps

module gscm_queue import gscm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   always_comb begin
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count above depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count missed a transfer in");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("queue count missed a transfer out");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push && (count_ff == '0)) |=> out_valid)
      else $error("entry pushed into empty queue not presented");

endmodule

>>> rtl/gscm_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage,
// three channels side by side. Depends on gscm_pkg.
`timescale 1ns / 1ps

module gscm_back import gscm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_red,
   output logic [7:0]  out_green,
   output logic [7:0]  out_blue
);

   localparam int STAGES = QUOT_W;

   logic [STAGES-1:0]  vld_ff, vld_in;
   logic [NUM_W-1:0]   rem_ff [STAGES][CHANNELS];
   logic [NUM_W-1:0]   rem_in [STAGES][CHANNELS];
   logic [QUOT_W-1:0]  quo_ff [STAGES][CHANNELS];
   logic [QUOT_W-1:0]  quo_in [STAGES][CHANNELS];
   logic [DEN_W-1:0]   den_ff [STAGES];
   logic [DEN_W-1:0]   den_in [STAGES];
   logic               advance;

   always_comb begin
      logic [NUM_W-1:0]  src_rem [CHANNELS];
      logic [QUOT_W-1:0] src_quo [CHANNELS];
      logic [DEN_W-1:0]  src_den;
      logic              src_vld;
      logic [NUM_W:0]    dsh;
      logic [NUM_W:0]    diff;

      advance = !vld_ff[STAGES-1] || out_ready;
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            src_rem[0] = in_item.num_r;
            src_rem[1] = in_item.num_g;
            src_rem[2] = in_item.num_b;
            for (int c = 0; c < CHANNELS; c++) begin
               src_quo[c] = '0;
            end
            src_den = in_item.den;
            src_vld = in_valid;
         end else begin
            for (int c = 0; c < CHANNELS; c++) begin
               src_rem[c] = rem_ff[s-1][c];
               src_quo[c] = quo_ff[s-1][c];
            end
            src_den = den_ff[s-1];
            src_vld = vld_ff[s-1];
         end
         dsh = (NUM_W + 1)'(src_den) << (STAGES - 1 - s);
         for (int c = 0; c < CHANNELS; c++) begin
            diff         = {1'b0, src_rem[c]} - dsh;
            rem_in[s][c] = src_rem[c];
            quo_in[s][c] = src_quo[c];
            if (!diff[NUM_W]) begin
               rem_in[s][c]                 = diff[NUM_W-1:0];
               quo_in[s][c][STAGES - 1 - s] = 1'b1;
            end
         end
         den_in[s] = src_den;
         vld_in[s] = src_vld;
      end
   end

   assign in_ready  = advance;
   assign out_valid = vld_ff[STAGES-1];
   assign out_red   = quo_ff[STAGES-1][0];
   assign out_green = quo_ff[STAGES-1][1];
   assign out_blue  = quo_ff[STAGES-1][2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         den_ff <= den_in;
      end
   end

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for gradient_stop_colormap_unit: directed table, then random phases.
// Predicts each colour from its own copy of the stop registers and checks rsp transfers.
// Depends on gscm_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_top;
   import gscm_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int TAIL_CYCLES   = 24;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASE_COUNT   = 7;
   localparam int PHASE_ITEMS   = 100;
   localparam int IDLE_PCT      = 29;
   // No register lives at this index; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   // Colour as carried on rsp_tdata: red in the low byte.
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] wdata;
      logic [7:0]            lvl;
      logic                  fixed;   // colour below is typed in, not predicted
      rgb_type               want;    // {blue, green, red}
   } row_type;

   // Directed plan. Register writes wait for the unit to drain first.
   localparam int PLAN_ROWS = 31;
   localparam row_type PLAN [PLAN_ROWS] = '{
      // reset gradient: black at 0, white at 255
      '{ROW_ITEM, 3'd0, 32'd0, 8'd0,   1'b1, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd255, 1'b1, 24'hFFFFFF},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd128, 1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd1,   1'b0, 24'h000000},
      // zero stop count acts as a single stop
      '{ROW_CSR,  REG_STOP_0,     32'h10AB_CDEF, 8'd0, 1'b0, 24'h000000},
      '{ROW_CSR,  REG_STOP_COUNT, 32'd0,         8'd0, 1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd0,   1'b1, 24'hEFCDAB},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd255, 1'b1, 24'hEFCDAB},
      '{ROW_CSR,  REG_STOP_COUNT, 32'd1,         8'd0, 1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd77,  1'b1, 24'hEFCDAB},
      // equal positions: zero span takes the lower stop
      '{ROW_CSR,  REG_STOP_0 + 3'd1, 32'h1000_0000, 8'd0, 1'b0, 24'h000000},
      '{ROW_CSR,  REG_STOP_COUNT,    32'd2,         8'd0, 1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd200, 1'b1, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd5,   1'b1, 24'hEFCDAB},
      // six stops, one out of order, count above the maximum
      '{ROW_CSR,  REG_STOP_0 + 3'd1, 32'h40FF_0080, 8'd0, 1'b0, 24'h000000},
      '{ROW_CSR,  REG_STOP_0 + 3'd2, 32'h8000_FF00, 8'd0, 1'b0, 24'h000000},
      '{ROW_CSR,  REG_STOP_0 + 3'd3, 32'hC012_3456, 8'd0, 1'b0, 24'h000000},
      '{ROW_CSR,  REG_STOP_0 + 3'd4, 32'h60FF_FFFF, 8'd0, 1'b0, 24'h000000},
      '{ROW_CSR,  REG_STOP_0 + 3'd5, 32'hFF80_8080, 8'd0, 1'b0, 24'h000000},
      '{ROW_CSR,  REG_STOP_COUNT,    32'd7,         8'd0, 1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd16,  1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd40,  1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd41,  1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd100, 1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd128, 1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd150, 1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd192, 1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd200, 1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd255, 1'b0, 24'h000000},
      // write to an index with no register behind it
      '{ROW_CSR,  REG_UNUSED, 32'hDEAD_BEEF, 8'd0, 1'b0, 24'h000000},
      '{ROW_ITEM, 3'd0, 32'd0, 8'd100, 1'b0, 24'h000000}
   };

   // DUT ports; every input starts at a known value.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;

   // Shadow of the stop registers used by the colour predictor.
   logic [STOP_CNT_W-1:0] shadow_count;
   stop_type              shadow_stops [MAX_STOPS_DEF];

   rgb_type colors_due [$];
   rgb_type got_color;
   rgb_type due_color;

   int  fail_count     = 0;
   int  level_count    = 0;
   int  directed_count = 0;
   int  colors_checked = 0;
   int  setting_count  = 0;
   int  cycle_count    = 0;
   bit  sender_gaps    = 1'b1;
   bit  sink_stalls    = 1'b1;
   bit  hold_off_req   = 1'b0;

   gradient_stop_colormap_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] level
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [7:0] red, [15:8] green, [23:16] blue
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Round half away from zero of ca + (cb - ca) * delta / span; all terms are
   // non-negative so the integer form is exact.
   function automatic logic [7:0] blend_channel(input logic [7:0] ca, input logic [7:0] cb,
                                                input int unsigned delta,
                                                input int unsigned span);
      int unsigned num;
      if (span == 0) return ca;
      num = ca * (span - delta) + cb * delta;
      return 8'((2 * num + span) / (2 * span));
   endfunction

   function automatic rgb_type predict_color(input logic [7:0] lvl);
      int unsigned n, k, kb, span, delta;
      stop_type    sa, sb;
      rgb_type     c;
      n = shadow_count;
      if (n < 1) n = 1;
      if (n > MAX_STOPS_DEF) n = MAX_STOPS_DEF;
      // Segment: first stop whose successor does not sit strictly below the level.
      k = 0;
      while (k + 1 < n && shadow_stops[k + 1].pos < lvl) k++;
      kb = (k + 1 < n) ? k + 1 : n - 1;
      sa = shadow_stops[k];
      sb = shadow_stops[kb];
      span  = 0;
      delta = 0;
      if (sb.pos > sa.pos) begin
         span  = sb.pos - sa.pos;
         delta = (lvl > sa.pos) ? lvl - sa.pos : 0;
         if (delta > span) delta = span;
      end
      c.red   = blend_channel(sa.red,   sb.red,   delta, span);
      c.green = blend_channel(sa.green, sb.green, delta, span);
      c.blue  = blend_channel(sa.blue,  sb.blue,  delta, span);
      return c;
   endfunction

   // Drive one register write; it lands at the next rising edge. Leave csr_we
   // high so back-to-back writes need no second assignment in one step.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == REG_STOP_COUNT)
         shadow_count = data[STOP_CNT_W-1:0];
      else if (idx >= REG_STOP_0 && idx < REG_STOP_0 + STOP_REGS)
         shadow_stops[idx - REG_STOP_0] = data;
   endtask

   // Offer one level and hold it until the transfer; log the colour it must produce.
   task automatic push_level(input logic [7:0] lvl, input logic fixed, input rgb_type want);
      csr_we     <= 1'b0;
      req_tvalid <= 1'b1;
      req_tdata  <= lvl;
      do @(posedge clock); while (!req_tready);
      colors_due.push_back(fixed ? want : predict_color(lvl));
      level_count++;
      // Drop valid now and then so gaps land on every pipe phase.
      if (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic drain_colors();
      req_tvalid <= 1'b0;
      while (colors_due.size() != 0) @(posedge clock);
   endtask

   // Levels cluster around stop positions half the time to hit segment edges.
   function automatic logic [7:0] pick_level();
      int near;
      if ($urandom_range(99) < 50) begin
         near = shadow_stops[$urandom_range(0, MAX_STOPS_DEF - 1)].pos;
         return 8'(near + $urandom_range(0, 2) - 1);
      end
      return 8'($urandom);
   endfunction

   // Load a full stop setting for one random phase.
   task automatic load_stop_setting(input int phase);
      logic [STOP_CNT_W-1:0] count;
      logic [CSR_DATA_W-1:0] word;
      int                    pos;
      case (phase)
         0: count = 3'd6;
         1: count = 3'd7;
         2: count = 3'd1;
         3: count = 3'd3;
         4: count = 3'd0;
         6: count = 3'd6;
         default: count = 3'($urandom_range(0, 7));
      endcase
      pos = $urandom_range(0, 40);
      for (int i = 0; i < STOP_REGS; i++) begin
         word = $urandom;
         if (phase == 6) begin
            // Extremes: evenly spread over the full range, black and white.
            word = (i % 2 == 0) ? 32'h0000_0000 : 32'h00FF_FFFF;
            word[31:24] = 8'(i * 51);
         end else if (phase != 5) begin
            // Sorted positions with random spacing; repeats allowed.
            word[31:24] = 8'(pos);
            pos = pos + $urandom_range(0, 70);
            if (pos > 255) pos = 255;
         end
         write_reg(REG_STOP_0 + 3'(i), word);
      end
      write_reg(REG_STOP_COUNT, {29'd0, count});
      if ($urandom_range(1) == 1) write_reg(REG_UNUSED, $urandom);
      setting_count++;
   endtask

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin : rsp_sink
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (sink_stalls) begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Check every rsp transfer against the oldest pending colour.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_color = rgb_type'(rsp_tdata);
         if (colors_due.size() == 0) begin
            $error("rsp transfer with nothing pending: %h", rsp_tdata);
            fail_count++;
         end else begin
            due_color = colors_due.pop_front();
            colors_checked++;
            if (got_color.red !== due_color.red) begin
               $error("red: expected %h, got %h", due_color.red, got_color.red);
               fail_count++;
            end
            if (got_color.green !== due_color.green) begin
               $error("green: expected %h, got %h", due_color.green, got_color.green);
               fail_count++;
            end
            if (got_color.blue !== due_color.blue) begin
               $error("blue: expected %h, got %h", due_color.blue, got_color.blue);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      // Shadow registers start at the reset values.
      foreach (shadow_stops[i]) shadow_stops[i] = '0;
      shadow_stops[1] = STOP_1_RST;
      shadow_count    = STOP_COUNT_RST;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed plan.
      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (PLAN[r].kind == ROW_CSR) begin
            drain_colors();
            write_reg(PLAN[r].idx, PLAN[r].wdata);
         end else begin
            push_level(PLAN[r].lvl, PLAN[r].fixed, PLAN[r].want);
         end
      end
      directed_count = level_count;

      // Random phases, each with its own stop setting.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_colors();
         load_stop_setting(p);
         // Phase 3 runs flat out on both sides.
         sender_gaps = (p != 3);
         sink_stalls = (p != 3);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Hold the receiver off while levels keep coming, to back up the pipe.
            if (p == 1 && i == 10) hold_off_req = 1'b1;
            push_level(pick_level(), 1'b0, '0);
         end
      end

      drain_colors();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Coverage: %0d levels sent (%0d directed), %0d colours checked,",
               level_count, directed_count, colors_checked);
      $display("          %0d random stop settings including count extremes.", setting_count);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
